// File: sv/csr_to_csc_transpose_core_assert.svh
// assertion macros for the csr to csc transpose core
// expects clk_i and rst_ni in the scope of the including module
`ifndef CSR_TO_CSC_TRANSPOSE_CORE_ASSERT_SVH
`define CSR_TO_CSC_TRANSPOSE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define C2CT_ASSERT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define C2CT_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/c2ct_pkg.sv
// shared widths, codes and defaults of the csr to csc transpose core
// no dependencies
`default_nettype none

package c2ct_pkg;

  // payload field widths
  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned DATA_W      = 13;
  localparam int unsigned NODE_CNT_W  = 11;
  localparam int unsigned EDGE_CNT_W  = 13;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;

  // default capacity
  localparam int unsigned DEF_MAX_NODES = 1024;
  localparam int unsigned DEF_MAX_EDGES = 4096;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT = 2'd1;

  // request actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_WR_ROW_START = 3'd0,
    ACT_WR_COL_IDX   = 3'd1,
    ACT_TRANSPOSE    = 3'd2,
    ACT_RD_COL_START = 3'd3,
    ACT_RD_ROW_IDX   = 3'd4
  } action_e;

endpackage

`default_nettype wire

// File: sv/c2ct_if.sv
// channel interfaces of the csr to csc transpose core
// depends on c2ct_pkg
`default_nettype none

// request channel: action, entry index and write value
interface c2ct_req_if import c2ct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [DATA_W-1:0]   index;
  logic [DATA_W-1:0]   value;

  modport source (output valid, output action, output index, output value, input ready);
  modport sink   (input valid, input action, input index, input value, output ready);
endinterface

// response channel: read data and range flag
interface c2ct_rsp_if import c2ct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic              status;

  modport source (output valid, output data_out, output status, input ready);
  modport sink   (input valid, input data_out, input status, output ready);
endinterface

// configuration write channel
interface c2ct_cfg_if import c2ct_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/csr_to_csc_transpose_core.sv
// csr to csc sparse matrix transpose core with sequencer and stores
// depends on c2ct_pkg, c2ct_if, c2ct_ram and the assertion header
//
// Usage: node_count and edge_count are set on the cfg channel while idle.
// The graph is loaded in csr form with write requests (row offsets, then
// column index per edge), converted by one transpose request and read back
// one csc entry per read request. Every request gives exactly one response;
// status is set for an index out of range or an unknown action.
// Requests are taken one at a time: ready is high only while the sequencer
// is idle. A write goes straight to the response state; a read first waits
// for the registered memory read. A transpose is a stable counting sort run
// by the sequencer over the memory ports: clear counters, count pass, prefix
// pass, placement pass, zero the unused tail. Reset clears the sequencer, the
// output valid and both count registers; the stores hold nothing until
// written. A stalled response stays in the output register; the next request
// may still be taken, but its response waits in the response state until the
// output register is free.
`default_nettype none

`include "csr_to_csc_transpose_core_assert.svh"

module csr_to_csc_transpose_core import c2ct_pkg::*; #(
  parameter int unsigned MAX_NODES = DEF_MAX_NODES,
  parameter int unsigned MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  c2ct_cfg_if.sink   cfg_i,
  c2ct_req_if.sink   req_i,
  c2ct_rsp_if.source rsp_o
);

  localparam int unsigned NODE_AW = $clog2(MAX_NODES + 1);
  localparam int unsigned EDGE_AW = $clog2(MAX_EDGES);
  localparam int unsigned CNT_W   = $clog2(MAX_EDGES + 1);
  localparam int unsigned ROW_W   = $clog2(MAX_NODES);
  localparam int unsigned CMP_A   = (DATA_W > NODE_AW) ? DATA_W : NODE_AW;
  localparam int unsigned CMP_W   = (CMP_A > CNT_W) ? CMP_A : CNT_W;

  typedef enum logic [12:0] {
    ST_IDLE      = 13'h0001,
    ST_RD_WAIT   = 13'h0002,
    ST_RESP      = 13'h0004,
    ST_CLR       = 13'h0008,
    ST_START     = 13'h0010,
    ST_LO_WAIT   = 13'h0020,
    ST_ROW       = 13'h0040,
    ST_HI_WAIT   = 13'h0080,
    ST_EDGE      = 13'h0100,
    ST_COL_WAIT  = 13'h0200,
    ST_FILL_WAIT = 13'h0400,
    ST_PFX_RD    = 13'h0800,
    ST_PFX_WR    = 13'h1000
  } state_e;

  // the tail sweep reuses the edge state with a flag
  state_e state_q, state_d;

  logic                  pass_q, pass_d;     // 0 count pass, 1 placement pass
  logic                  tail_q, tail_d;     // zeroing the unused tail
  logic [NODE_AW-1:0]    r_q, r_d;
  logic [NODE_AW-1:0]    c_q, c_d;
  logic [NODE_AW-1:0]    col_q, col_d;
  logic [CNT_W-1:0]      e_q, e_d;
  logic [CNT_W-1:0]      hi_q, hi_d;
  logic [CNT_W-1:0]      p_q, p_d;
  logic [CNT_W-1:0]      acc_q, acc_d;
  logic                  rd_row_q, rd_row_d;
  logic [DATA_W-1:0]     pend_data_q, pend_data_d;
  logic                  pend_status_q, pend_status_d;
  logic [NODE_CNT_W-1:0] node_count_q;
  logic [EDGE_CNT_W-1:0] edge_count_q;
  logic                  out_valid_q, out_valid_d;
  logic [DATA_W-1:0]     out_data_q;
  logic                  out_status_q;

  logic             req_acc;
  logic             out_free;
  logic             out_load;
  logic [CMP_W-1:0] idx_w;
  logic [CMP_W-1:0] n_w;
  logic [CMP_W-1:0] m_w;
  logic [CMP_W-1:0] ce_w;

  // store ports
  logic               rs_we;
  logic [NODE_AW-1:0] rs_waddr, rs_raddr;
  logic [DATA_W-1:0]  rs_rdata;
  logic               ce_we;
  logic [EDGE_AW-1:0] ce_waddr, ce_raddr;
  logic [DATA_W-1:0]  ce_rdata;
  logic               cs_we;
  logic [NODE_AW-1:0] cs_raddr;
  logic [CNT_W-1:0]   cs_rdata;
  logic               roe_we;
  logic [EDGE_AW-1:0] roe_waddr, roe_raddr;
  logic [ROW_W-1:0]   roe_wdata, roe_rdata;
  logic               fill_we;
  logic [NODE_AW-1:0] fill_waddr, fill_raddr;
  logic [CNT_W-1:0]   fill_wdata, fill_rdata;

  // row offsets clamped to the edge count in use
  function automatic logic [CNT_W-1:0] clamp_m(input logic [DATA_W-1:0] x,
                                               input logic [CMP_W-1:0]  m);
    logic [CMP_W-1:0] xw;
    xw = CMP_W'(x);
    if (xw > m) begin
      return m[CNT_W-1:0];
    end
    return xw[CNT_W-1:0];
  endfunction

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= '0;
      edge_count_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_NODE_COUNT) begin
        node_count_q <= cfg_i.data[NODE_CNT_W-1:0];
      end else if (cfg_i.index == CFG_EDGE_COUNT) begin
        edge_count_q <= cfg_i.data[EDGE_CNT_W-1:0];
      end
    end
  end

  // counts in use, saturated at capacity
  assign n_w = (CMP_W'(node_count_q) > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES)
                                                          : CMP_W'(node_count_q);
  assign m_w = (CMP_W'(edge_count_q) > CMP_W'(MAX_EDGES)) ? CMP_W'(MAX_EDGES)
                                                          : CMP_W'(edge_count_q);

  // handshakes
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign out_load    = (state_q == ST_RESP) && out_free;
  assign idx_w       = CMP_W'(req_i.index);
  assign ce_w        = CMP_W'(ce_rdata);

  // request decode and transpose sequencer
  always_comb begin
    state_d       = state_q;
    pass_d        = pass_q;
    tail_d        = tail_q;
    r_d           = r_q;
    c_d           = c_q;
    col_d         = col_q;
    e_d           = e_q;
    hi_d          = hi_q;
    p_d           = p_q;
    acc_d         = acc_q;
    rd_row_d      = rd_row_q;
    pend_data_d   = pend_data_q;
    pend_status_d = pend_status_q;

    rs_we      = 1'b0;
    rs_waddr   = idx_w[NODE_AW-1:0];
    rs_raddr   = '0;
    ce_we      = 1'b0;
    ce_waddr   = idx_w[EDGE_AW-1:0];
    ce_raddr   = e_q[EDGE_AW-1:0];
    cs_we      = 1'b0;
    cs_raddr   = idx_w[NODE_AW-1:0];
    roe_we     = 1'b0;
    roe_waddr  = e_q[EDGE_AW-1:0];
    roe_wdata  = '0;
    roe_raddr  = idx_w[EDGE_AW-1:0];
    fill_we    = 1'b0;
    fill_waddr = c_q;
    fill_wdata = '0;
    fill_raddr = c_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          pend_data_d   = '0;
          pend_status_d = 1'b0;
          state_d       = ST_RESP;
          unique case (req_i.action)
            ACT_WR_ROW_START: begin
              if (idx_w <= CMP_W'(MAX_NODES)) begin
                rs_we = 1'b1;
              end else begin
                pend_status_d = 1'b1;
              end
            end
            ACT_WR_COL_IDX: begin
              if (idx_w < CMP_W'(MAX_EDGES)) begin
                ce_we = 1'b1;
              end else begin
                pend_status_d = 1'b1;
              end
            end
            ACT_TRANSPOSE: begin
              c_d     = '0;
              pass_d  = 1'b0;
              tail_d  = 1'b0;
              state_d = ST_CLR;
            end
            ACT_RD_COL_START: begin
              if (idx_w <= n_w) begin
                rd_row_d = 1'b0;
                state_d  = ST_RD_WAIT;
              end else begin
                pend_status_d = 1'b1;
              end
            end
            ACT_RD_ROW_IDX: begin
              if (idx_w < m_w) begin
                rd_row_d = 1'b1;
                state_d  = ST_RD_WAIT;
              end else begin
                pend_status_d = 1'b1;
              end
            end
            default: begin
              pend_status_d = 1'b1;
            end
          endcase
        end
      end

      ST_RD_WAIT: begin
        pend_data_d = rd_row_q ? DATA_W'(roe_rdata) : DATA_W'(cs_rdata);
        state_d     = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      // zero the per-column counters
      ST_CLR: begin
        if (CMP_W'(c_q) < n_w) begin
          fill_we = 1'b1;
        end
        if (CMP_W'(c_q) + CMP_W'(1) >= n_w) begin
          state_d = ST_START;
        end else begin
          c_d = c_q + NODE_AW'(1);
        end
      end

      // start a walk over the csr rows
      ST_START: begin
        rs_raddr = '0;
        r_d      = '0;
        p_d      = '0;
        state_d  = ST_LO_WAIT;
      end

      ST_LO_WAIT: begin
        e_d     = clamp_m(rs_rdata, m_w);
        state_d = ST_ROW;
      end

      ST_ROW: begin
        if (CMP_W'(r_q) < n_w && CMP_W'(p_q) < m_w) begin
          rs_raddr = r_q + NODE_AW'(1);
          state_d  = ST_HI_WAIT;
        end else if (!pass_q) begin
          c_d     = '0;
          acc_d   = '0;
          state_d = ST_PFX_RD;
        end else begin
          e_d     = p_q;
          tail_d  = 1'b1;
          state_d = ST_EDGE;
        end
      end

      ST_HI_WAIT: begin
        hi_d    = clamp_m(rs_rdata, m_w);
        state_d = ST_EDGE;
      end

      // next edge of the row, or the tail sweep after placement
      ST_EDGE: begin
        if (tail_q) begin
          if (CMP_W'(e_q) < m_w) begin
            roe_we = 1'b1;
            e_d    = e_q + CNT_W'(1);
          end else begin
            tail_d        = 1'b0;
            pend_data_d   = '0;
            pend_status_d = 1'b0;
            state_d       = ST_RESP;
          end
        end else if (e_q < hi_q && CMP_W'(p_q) < m_w) begin
          state_d = ST_COL_WAIT;
        end else begin
          r_d     = r_q + NODE_AW'(1);
          e_d     = hi_q;
          state_d = ST_ROW;
        end
      end

      // drop edges whose column is out of range
      ST_COL_WAIT: begin
        col_d      = ce_w[NODE_AW-1:0];
        fill_raddr = ce_w[NODE_AW-1:0];
        if (ce_w < n_w) begin
          state_d = ST_FILL_WAIT;
        end else begin
          e_d     = e_q + CNT_W'(1);
          state_d = ST_EDGE;
        end
      end

      // count, or place the row at the column cursor
      ST_FILL_WAIT: begin
        fill_we    = 1'b1;
        fill_waddr = col_q;
        fill_wdata = fill_rdata + CNT_W'(1);
        if (pass_q) begin
          roe_we    = 1'b1;
          roe_waddr = fill_rdata[EDGE_AW-1:0];
          roe_wdata = r_q[ROW_W-1:0];
        end
        p_d     = p_q + CNT_W'(1);
        e_d     = e_q + CNT_W'(1);
        state_d = ST_EDGE;
      end

      ST_PFX_RD: begin
        fill_raddr = c_q;
        state_d    = ST_PFX_WR;
      end

      // column offset is the running sum; the cursor starts there
      ST_PFX_WR: begin
        cs_we = 1'b1;
        if (CMP_W'(c_q) == n_w) begin
          pass_d  = 1'b1;
          state_d = ST_START;
        end else begin
          fill_we    = 1'b1;
          fill_wdata = acc_q;
          acc_d      = acc_q + fill_rdata;
          c_d        = c_q + NODE_AW'(1);
          state_d    = ST_PFX_RD;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // response register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= 1'b0;
      tail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  // counters and payload
  always_ff @(posedge clk_i) begin
    r_q           <= r_d;
    c_q           <= c_d;
    col_q         <= col_d;
    e_q           <= e_d;
    hi_q          <= hi_d;
    p_q           <= p_d;
    acc_q         <= acc_d;
    rd_row_q      <= rd_row_d;
    pend_data_q   <= pend_data_d;
    pend_status_q <= pend_status_d;
    if (out_load) begin
      out_data_q   <= pend_data_q;
      out_status_q <= pend_status_q;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.data_out = out_data_q;
  assign rsp_o.status   = out_status_q;

  // csr row offsets
  c2ct_ram #(.DEPTH(MAX_NODES + 1), .WIDTH(DATA_W), .AW(NODE_AW)) u_row_start (
    .clk_i   (clk_i),
    .we_i    (rs_we),
    .waddr_i (rs_waddr),
    .wdata_i (req_i.value),
    .raddr_i (rs_raddr),
    .rdata_o (rs_rdata)
  );

  // csr column index of each edge
  c2ct_ram #(.DEPTH(MAX_EDGES), .WIDTH(DATA_W), .AW(EDGE_AW)) u_col_of_edge (
    .clk_i   (clk_i),
    .we_i    (ce_we),
    .waddr_i (ce_waddr),
    .wdata_i (req_i.value),
    .raddr_i (ce_raddr),
    .rdata_o (ce_rdata)
  );

  // csc column offsets
  c2ct_ram #(.DEPTH(MAX_NODES + 1), .WIDTH(CNT_W), .AW(NODE_AW)) u_col_start (
    .clk_i   (clk_i),
    .we_i    (cs_we),
    .waddr_i (c_q),
    .wdata_i (acc_q),
    .raddr_i (cs_raddr),
    .rdata_o (cs_rdata)
  );

  // csc row index of each edge
  c2ct_ram #(.DEPTH(MAX_EDGES), .WIDTH(ROW_W), .AW(EDGE_AW)) u_row_of_edge (
    .clk_i   (clk_i),
    .we_i    (roe_we),
    .waddr_i (roe_waddr),
    .wdata_i (roe_wdata),
    .raddr_i (roe_raddr),
    .rdata_o (roe_rdata)
  );

  // per-column counts, then placement cursors
  c2ct_ram #(.DEPTH(MAX_NODES + 1), .WIDTH(CNT_W), .AW(NODE_AW)) u_fill (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .raddr_i (fill_raddr),
    .rdata_o (fill_rdata)
  );

  // checks
  `C2CT_ASSERT_NEXT(a_resp_to_idle, out_load, out_valid_q && state_q == ST_IDLE, "response lost")
  `C2CT_ASSERT(a_place_in_range, state_q == ST_FILL_WAIT && pass_q, CMP_W'(fill_rdata) < m_w, "placement beyond edge count")
  `C2CT_ASSERT(a_walk_bound, state_q == ST_EDGE && !tail_q, CMP_W'(p_q) <= m_w, "edge walk past edge count")
  `C2CT_ASSERT_NEXT(a_one_request, req_acc, !req_i.ready, "second request taken while busy")

endmodule

`default_nettype wire

// File: sv/c2ct_ram.sv
// simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module c2ct_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 1,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: tb/sv/tb_csr_to_csc_transpose_core.sv
// self-checking testbench of the csr to csc transpose core: loads graphs, transposes, reads back
// depends on c2ct_pkg, c2ct_if and csr_to_csc_transpose_core
`timescale 1ns / 100ps

module tb_csr_to_csc_transpose_core;
  import c2ct_pkg::*;

  localparam int unsigned MAX_NODES = DEF_MAX_NODES;
  localparam int unsigned MAX_EDGES = DEF_MAX_EDGES;
  localparam int unsigned IDX_MAX   = (1 << DATA_W) - 1;
  localparam logic [ACTION_W-1:0] ACT_CODE_MAX = '1;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              status;
  } rsp_t;

  logic clk_i;
  logic rst_ni;

  c2ct_cfg_if cfg_if ();
  c2ct_req_if req_if ();
  c2ct_rsp_if rsp_if ();

  csr_to_csc_transpose_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow copy of the graph stores and sizes
  bit [DATA_W-1:0]     row_ptr_mdl [0:MAX_NODES];
  bit [DATA_W-1:0]     col_idx_mdl [0:MAX_EDGES-1];
  bit [DATA_W-1:0]     col_ptr_mdl [0:MAX_NODES];
  bit [DATA_W-1:0]     row_idx_mdl [0:MAX_EDGES-1];
  bit                  row_ptr_set [0:MAX_NODES];
  bit                  col_idx_set [0:MAX_EDGES-1];
  bit                  col_ptr_set [0:MAX_NODES];
  bit                  row_idx_set [0:MAX_EDGES-1];
  bit [NODE_CNT_W-1:0] node_cnt_mdl;
  bit [EDGE_CNT_W-1:0] edge_cnt_mdl;

  // scratch for the counting sort
  int unsigned pair_row [0:MAX_EDGES-1];
  int unsigned pair_col [0:MAX_EDGES-1];
  int unsigned fill_pos [0:MAX_NODES];

  rsp_t pending_rsp_q [$];
  int   err_cnt;
  int   req_cnt;
  int   rsp_cnt;
  int   transpose_cnt;
  int   src_idle_pct;
  int   sink_idle_pct;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("csr_to_csc_transpose_core: mismatch");
    $finish;
  end

  // response backpressure
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  function automatic int unsigned used_nodes();
    return (node_cnt_mdl > MAX_NODES) ? MAX_NODES : node_cnt_mdl;
  endfunction

  function automatic int unsigned used_edges();
    return (edge_cnt_mdl > MAX_EDGES) ? MAX_EDGES : edge_cnt_mdl;
  endfunction

  // csr to csc conversion as a stable counting sort by column
  function automatic void build_csc();
    int unsigned n, m, p, lo, hi, col, r, e, c;
    n = used_nodes();
    m = used_edges();
    p = 0;
    // expand row spans into (row, column) pairs
    for (r = 0; r < n && p < m; r++) begin
      lo = row_ptr_mdl[r];
      hi = row_ptr_mdl[r+1];
      if (lo > m) lo = m;
      if (hi > m) hi = m;
      for (e = lo; e < hi && p < m; e++) begin
        col = col_idx_mdl[e];
        if (col < n) begin
          pair_row[p] = r;
          pair_col[p] = col;
          p++;
        end
      end
    end
    // histogram and prefix sum give the column offsets
    for (c = 0; c <= n; c++) fill_pos[c] = 0;
    for (e = 0; e < p; e++) fill_pos[pair_col[e]+1]++;
    for (c = 1; c <= n; c++) fill_pos[c] += fill_pos[c-1];
    for (c = 0; c <= n; c++) begin
      col_ptr_mdl[c] = fill_pos[c];
      col_ptr_set[c] = 1'b1;
    end
    // placement, then zero the unused tail
    for (e = 0; e < p; e++) begin
      row_idx_mdl[fill_pos[pair_col[e]]] = pair_row[e];
      fill_pos[pair_col[e]]++;
    end
    for (e = p; e < m; e++) row_idx_mdl[e] = '0;
    for (e = 0; e < m; e++) row_idx_set[e] = 1'b1;
  endfunction

  // expected response of one request, updates the shadow stores
  function automatic rsp_t predict_rsp(input logic [ACTION_W-1:0] act,
                                       input logic [DATA_W-1:0] idx,
                                       input logic [DATA_W-1:0] val);
    rsp_t rsp;
    rsp = '0;
    case (act)
      ACT_WR_ROW_START: begin
        if (idx <= MAX_NODES) begin
          row_ptr_mdl[idx] = val;
          row_ptr_set[idx] = 1'b1;
        end else begin
          rsp.status = 1'b1;
        end
      end
      ACT_WR_COL_IDX: begin
        if (idx < MAX_EDGES) begin
          col_idx_mdl[idx] = val;
          col_idx_set[idx] = 1'b1;
        end else begin
          rsp.status = 1'b1;
        end
      end
      ACT_TRANSPOSE: build_csc();
      ACT_RD_COL_START: begin
        if (idx <= used_nodes()) rsp.data = col_ptr_mdl[idx];
        else rsp.status = 1'b1;
      end
      ACT_RD_ROW_IDX: begin
        if (idx < used_edges()) rsp.data = row_idx_mdl[idx];
        else rsp.status = 1'b1;
      end
      default: rsp.status = 1'b1;
    endcase
    return rsp;
  endfunction

  task automatic report_mismatch(input string what);
    if (err_cnt < 100) $display("ERROR %0t: %s", $time, what);
    err_cnt++;
  endtask

  // compare each taken response with the oldest expectation
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      rsp_cnt++;
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        exp_rsp = pending_rsp_q.pop_front();
        if (rsp_if.data_out !== exp_rsp.data)
          report_mismatch($sformatf("data_out %0d, expected %0d", rsp_if.data_out,
                                    exp_rsp.data));
        if (rsp_if.status !== exp_rsp.status)
          report_mismatch($sformatf("status %0b, expected %0b", rsp_if.status,
                                    exp_rsp.status));
      end
    end
  end

  // send one request with random lead-in gaps
  task automatic send_req(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] idx,
                          input logic [DATA_W-1:0] val);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.index  <= idx;
    req_if.value  <= val;
    do @(posedge clk_i); while (!req_if.ready);
    pending_rsp_q.push_back(predict_rsp(act, idx, val));
    req_cnt++;
  endtask

  // drop valid and wait until every response is back
  task automatic drain_responses();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] dat);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= dat;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_NODE_COUNT) node_cnt_mdl = dat[NODE_CNT_W-1:0];
    else if (idx == CFG_EDGE_COUNT) edge_cnt_mdl = dat[EDGE_CNT_W-1:0];
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_sizes(input int unsigned node_val, input int unsigned edge_val);
    drain_responses();
    cfg_write(CFG_NODE_COUNT, CFG_DATA_W'(node_val));
    cfg_write(CFG_EDGE_COUNT, CFG_DATA_W'(edge_val));
  endtask

  // write every entry the transpose walks that still holds nothing
  task automatic load_missing();
    int unsigned n, m, lo, hi, r, e;
    n = used_nodes();
    m = used_edges();
    for (r = 0; r <= n; r++)
      if (!row_ptr_set[r])
        send_req(ACT_WR_ROW_START, DATA_W'(r), DATA_W'($urandom_range(0, m)));
    for (r = 0; r < n; r++) begin
      lo = row_ptr_mdl[r];
      hi = row_ptr_mdl[r+1];
      if (lo > m) lo = m;
      if (hi > m) hi = m;
      for (e = lo; e < hi; e++)
        if (!col_idx_set[e])
          send_req(ACT_WR_COL_IDX, DATA_W'(e), DATA_W'($urandom_range(0, n - 1)));
    end
  endtask

  task automatic run_transpose();
    load_missing();
    send_req(ACT_TRANSPOSE, DATA_W'($urandom_range(0, IDX_MAX)),
             DATA_W'($urandom_range(0, IDX_MAX)));
    transpose_cnt++;
  endtask

  // read one csc entry, in range only where it has been written
  task automatic read_random();
    int unsigned n, m, idx;
    n = used_nodes();
    m = used_edges();
    idx = 0;
    if ($urandom_range(0, 1)) begin
      idx = $urandom_range(0, n);
      if ($urandom_range(0, 4) == 0 || !col_ptr_set[idx]) idx = $urandom_range(n + 1, IDX_MAX);
      send_req(ACT_RD_COL_START, DATA_W'(idx), DATA_W'($urandom_range(0, IDX_MAX)));
    end else begin
      if (m > 0) idx = $urandom_range(0, m - 1);
      if (m == 0 || $urandom_range(0, 4) == 0 || !row_idx_set[idx])
        idx = $urandom_range(m, IDX_MAX);
      send_req(ACT_RD_ROW_IDX, DATA_W'(idx), DATA_W'($urandom_range(0, IDX_MAX)));
    end
  endtask

  // occasional unknown action or out of range write
  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: send_req(ACTION_W'($urandom_range(ACT_RD_ROW_IDX + 1, ACT_CODE_MAX)),
                    DATA_W'($urandom_range(0, IDX_MAX)), DATA_W'($urandom_range(0, IDX_MAX)));
        1: send_req(ACT_WR_ROW_START, DATA_W'($urandom_range(MAX_NODES + 1, IDX_MAX)),
                    DATA_W'($urandom_range(0, IDX_MAX)));
        default: send_req(ACT_WR_COL_IDX, DATA_W'($urandom_range(MAX_EDGES, IDX_MAX)),
                          DATA_W'($urandom_range(0, IDX_MAX)));
      endcase
    end
  endtask

  // one graph: resize, load csr (unless only resizing), transpose, read back
  task automatic graph_round(input bit resize_only);
    int unsigned n, m, r, e, off, val, step;
    case ($urandom_range(0, 9))
      0: n = 0;
      1: n = 1;
      2: n = $urandom_range(20, 40);
      default: n = $urandom_range(2, 12);
    endcase
    case ($urandom_range(0, 9))
      0: m = 0;
      1: m = $urandom_range(40, 64);
      default: m = $urandom_range(1, 30);
    endcase
    set_sizes(n, m);
    if (!resize_only) begin
      // mostly well-formed row offsets, a few corrupted
      off = 0;
      step = (n > 0) ? (2 * m) / n + 1 : 1;
      for (r = 0; r <= n; r++) begin
        if (r == n) off = m;
        else if (r > 0) off = (off + $urandom_range(0, step) > m) ? m
                                : off + $urandom_range(0, step);
        val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, IDX_MAX) : off;
        maybe_noise();
        send_req(ACT_WR_ROW_START, DATA_W'(r), DATA_W'(val));
      end
      // columns mostly in range
      for (e = 0; e < m; e++) begin
        val = (n == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(0, IDX_MAX)
                                                     : $urandom_range(0, n - 1);
        maybe_noise();
        send_req(ACT_WR_COL_IDX, DATA_W'(e), DATA_W'(val));
      end
    end
    run_transpose();
    repeat (n + m + $urandom_range(2, 6)) begin
      maybe_noise();
      read_random();
    end
  endtask

  // small graph with an empty row, a reversed span, a clamped span,
  // dropped columns, a short edge list and a trailing empty column
  task automatic test_directed_corners();
    set_sizes(4, 6);
    send_req(ACT_WR_ROW_START, 0, 0);
    send_req(ACT_WR_ROW_START, 1, 2);
    send_req(ACT_WR_ROW_START, 2, 1);
    send_req(ACT_WR_ROW_START, 3, 4);
    send_req(ACT_WR_ROW_START, 4, IDX_MAX);
    send_req(ACT_WR_COL_IDX, 0, 2);
    send_req(ACT_WR_COL_IDX, 1, 0);
    send_req(ACT_WR_COL_IDX, 2, 1);
    send_req(ACT_WR_COL_IDX, 3, IDX_MAX);
    send_req(ACT_WR_COL_IDX, 4, 4);
    send_req(ACT_WR_COL_IDX, 5, 1);
    // writes out of range and unknown actions
    send_req(ACT_WR_ROW_START, DATA_W'(MAX_NODES + 1), 5);
    send_req(ACT_WR_COL_IDX, DATA_W'(MAX_EDGES), 3);
    send_req(ACT_CODE_MAX, IDX_MAX, IDX_MAX);
    send_req(ACTION_W'(ACT_RD_ROW_IDX + 1), 0, 0);
    run_transpose();
    send_req(ACT_RD_COL_START, 0, 0);
    send_req(ACT_RD_COL_START, 4, 0);
    send_req(ACT_RD_COL_START, 5, 0);
    send_req(ACT_RD_ROW_IDX, 0, 0);
    send_req(ACT_RD_ROW_IDX, 5, 0);
    send_req(ACT_RD_ROW_IDX, 6, 0);
    send_req(ACT_RD_ROW_IDX, IDX_MAX, IDX_MAX);
  endtask

  task automatic test_random_graphs(input int rounds);
    repeat (rounds) graph_round($urandom_range(0, 3) == 0);
  endtask

  // full capacity graph with counts above the limits, then exact limits, then empty
  task automatic test_capacity_limits();
    int unsigned r, e, col;
    set_sizes(IDX_MAX, IDX_MAX);
    for (r = 0; r <= MAX_NODES; r++)
      send_req(ACT_WR_ROW_START, DATA_W'(r), DATA_W'(r * (MAX_EDGES / MAX_NODES)));
    for (e = 0; e < MAX_EDGES; e++) begin
      col = ($urandom_range(0, 99) == 0) ? $urandom_range(MAX_NODES, IDX_MAX)
                                         : $urandom_range(0, MAX_NODES - 1);
      send_req(ACT_WR_COL_IDX, DATA_W'(e), DATA_W'(col));
    end
    run_transpose();
    send_req(ACT_RD_COL_START, 0, 0);
    send_req(ACT_RD_COL_START, DATA_W'(MAX_NODES), 0);
    send_req(ACT_RD_COL_START, DATA_W'(MAX_NODES + 1), 0);
    send_req(ACT_RD_ROW_IDX, 0, 0);
    send_req(ACT_RD_ROW_IDX, DATA_W'(MAX_EDGES - 1), 0);
    send_req(ACT_RD_ROW_IDX, DATA_W'(MAX_EDGES), 0);
    repeat (40) read_random();
    set_sizes(MAX_NODES, MAX_EDGES);
    send_req(ACT_RD_COL_START, DATA_W'(MAX_NODES), 0);
    send_req(ACT_RD_ROW_IDX, DATA_W'(MAX_EDGES - 1), 0);
    send_req(ACT_RD_ROW_IDX, DATA_W'(MAX_EDGES), 0);
    set_sizes(0, 0);
    run_transpose();
    send_req(ACT_RD_COL_START, 0, 0);
    send_req(ACT_RD_COL_START, 1, 0);
    send_req(ACT_RD_ROW_IDX, 0, 0);
  endtask

  // stimulus sequence
  initial begin
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.action = '0;
    req_if.index  = '0;
    req_if.value  = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    err_cnt       = 0;
    req_cnt       = 0;
    rsp_cnt       = 0;
    transpose_cnt = 0;
    src_idle_pct  = 22;
    sink_idle_pct = 75;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_corners();
    test_random_graphs(4);
    src_idle_pct  = 75;
    sink_idle_pct = 22;
    test_random_graphs(4);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_graphs(4);
    test_capacity_limits();

    drain_responses();
    repeat (20) @(posedge clk_i);
    if (pending_rsp_q.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", pending_rsp_q.size()));
    $display("summary: %0d requests sent, %0d responses checked, %0d transposes", req_cnt,
             rsp_cnt, transpose_cnt);
    $display("summary: directed corners, random graphs under three idle mixes, full capacity");
    if (err_cnt == 0) begin
      $display("csr_to_csc_transpose_core: match");
    end else begin
      $display("csr_to_csc_transpose_core: mismatch");
    end
    $finish;
  end

endmodule
